// ===== hw/rtl/multilevel_feedback_queue_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler: assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition holds at every edge
`define MFQS_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mfqs check failed");
// Consequent holds in the same cycle as the antecedent
`define MFQS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mfqs check failed");
// Consequent holds in the cycle after the antecedent
`define MFQS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfqs check failed");
`else
`define MFQS_ASSERT(label, cond)
`define MFQS_ASSERT_IMP(label, ante, cons)
`define MFQS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/mfqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfqs_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mfqs_pkg;

    // Fixed field widths
    localparam int ID_W       = 8;
    localparam int PRIO_W     = 4;
    localparam int OPRIO_W    = 3;
    localparam int CODE_W     = 2;
    localparam int CFG_W      = 10;
    localparam logic [CFG_W-1:0] CFG_RESET = 10'd10;

    // Parameter defaults
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 20;

    typedef enum logic [CODE_W-1:0] {
        REQ_ADD  = 2'd0,
        REQ_GET  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_NONE = 2'd3
    } t_req_type;

    typedef enum logic [CODE_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_PRIO = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [CODE_W-1:0] {
        RSN_NONE    = 2'd0,
        RSN_DONE_IO = 2'd1,
        RSN_SLICE   = 2'd2,
        RSN_OTHER   = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic exec;
        logic cfg_we;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic req_none;
    } t_dp_sts;

endpackage

// ===== hw/rtl/mfqs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfqs_ctrl
// Request sequencer: capture, decide, execute, and the result strobe.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_defines.svh"

module mfqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output logic              o_done,
    output mfqs_pkg::t_dp_cmd o_cmd,
    input  mfqs_pkg::t_dp_sts i_sts
);

    mfqs_pkg::t_state r_state;
    mfqs_pkg::t_state n_state;
    logic             r_done;
    logic             n_done;

    // State and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfqs_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        o_cmd        = '0;
        o_cmd.cfg_we = i_cfg_valid && (r_state == mfqs_pkg::S_IDLE);
        case (r_state)
            mfqs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = mfqs_pkg::S_DECIDE;
                end
            end
            mfqs_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.req_none) begin
                    n_state = mfqs_pkg::S_IDLE;
                end else begin
                    n_state = mfqs_pkg::S_EXEC;
                end
            end
            mfqs_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_done     = 1'b1;
                n_state    = mfqs_pkg::S_IDLE;
            end
            default: begin
                n_state = mfqs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != mfqs_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == mfqs_pkg::S_IDLE);
    assign o_done      = r_done;

    `MFQS_ASSERT_NXT(a_start_decides, i_start && !o_busy, r_state == mfqs_pkg::S_DECIDE)
    `MFQS_ASSERT_NXT(a_exec_strobes, r_state == mfqs_pkg::S_EXEC, r_done && !o_busy)
    `MFQS_ASSERT_IMP(a_strobe_after_exec, r_done, $past(r_state) == mfqs_pkg::S_EXEC)

endmodule

// ===== hw/rtl/mfqs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfqs_dpath
// Level pointers and counts, entry memory, level adjust and result registers.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_defines.svh"

module mfqs_dpath #(
    parameter int NUM_LEVELS  = mfqs_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfqs_pkg::LEVEL_DEPTH_DEF,
    parameter int TIME_BITS   = mfqs_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfqs_pkg::t_dp_cmd             i_cmd,
    output mfqs_pkg::t_dp_sts             o_sts,
    input  logic [mfqs_pkg::CODE_W-1:0]   i_req_type,
    input  logic [mfqs_pkg::ID_W-1:0]     i_process_id,
    input  logic [mfqs_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [TIME_BITS-1:0]          i_last_run_time,
    input  logic [TIME_BITS-1:0]          i_cpu_remaining,
    input  logic [TIME_BITS-1:0]          i_time_until_io,
    input  logic [mfqs_pkg::CFG_W-1:0]    i_base_slice,
    output logic [mfqs_pkg::CODE_W-1:0]   o_status,
    output logic [mfqs_pkg::ID_W-1:0]     o_out_process_id,
    output logic [mfqs_pkg::OPRIO_W-1:0]  o_out_priority,
    output logic [TIME_BITS-1:0]          o_out_cpu_remaining,
    output logic [TIME_BITS-1:0]          o_out_time_until_io,
    output logic [TIME_BITS-1:0]          o_slice_length,
    output logic [mfqs_pkg::CODE_W-1:0]   o_reason
);

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int NUM_ENT = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(NUM_ENT);
    localparam int ENT_W   = mfqs_pkg::ID_W + 2 * TIME_BITS;
    localparam int SH_W    = mfqs_pkg::CFG_W + NUM_LEVELS - 1;
    localparam int SW      = (SH_W > TIME_BITS) ? SH_W : TIME_BITS;

    // Request capture
    mfqs_pkg::t_req_type           r_req;
    logic [mfqs_pkg::ID_W-1:0]     r_pid;
    logic [mfqs_pkg::PRIO_W-1:0]   r_preq;
    logic [TIME_BITS-1:0]          r_last;
    logic [TIME_BITS-1:0]          r_cpu;
    logic [TIME_BITS-1:0]          r_io;

    // Configuration and queue control
    logic [mfqs_pkg::CFG_W-1:0]    r_base;
    logic [PTR_W-1:0]              r_head [NUM_LEVELS];
    logic [PTR_W-1:0]              r_tail [NUM_LEVELS];
    logic [CNT_W-1:0]              r_cnt  [NUM_LEVELS];

    // Decide stage results
    logic [LVL_W-1:0]              r_lvl;
    logic                          r_empty;
    logic [TIME_BITS-1:0]          r_slice;

    // Entry memory and registered read
    logic [ENT_W-1:0]              mem [NUM_ENT];
    logic [ENT_W-1:0]              r_rd;

    // Result registers
    mfqs_pkg::t_status             r_status;
    logic [mfqs_pkg::ID_W-1:0]     r_opid;
    logic [mfqs_pkg::OPRIO_W-1:0]  r_oprio;
    logic [TIME_BITS-1:0]          r_ocpu;
    logic [TIME_BITS-1:0]          r_oio;
    logic [TIME_BITS-1:0]          r_oslice;
    mfqs_pkg::t_reason             r_oreason;

    // Combinational
    logic [LVL_W-1:0]              add_lvl;
    logic [TIME_BITS-1:0]          add_slice;
    logic [LVL_W-1:0]              n_lvl_add;
    logic [LVL_W-1:0]              first_lvl;
    logic                          any_level;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic                          bad_prio;
    logic                          lvl_full;
    logic                          wr_en;
    logic                          pop_en;
    logic [mfqs_pkg::ID_W-1:0]     rd_id;
    logic [TIME_BITS-1:0]          rd_cpu;
    logic [TIME_BITS-1:0]          rd_io;
    mfqs_pkg::t_status             n_status;
    logic [mfqs_pkg::ID_W-1:0]     n_opid;
    logic [mfqs_pkg::OPRIO_W-1:0]  n_oprio;
    logic [TIME_BITS-1:0]          n_ocpu;
    logic [TIME_BITS-1:0]          n_oio;
    logic [TIME_BITS-1:0]          n_oslice;
    mfqs_pkg::t_reason             n_oreason;

    // Slice of a level, saturated to the time width
    function automatic logic [TIME_BITS-1:0] f_slice(
        input logic [mfqs_pkg::CFG_W-1:0] base,
        input logic [LVL_W-1:0]           lvl
    );
        logic [SW-1:0] wide;
        wide = SW'(base) << lvl;
        if (wide > SW'({TIME_BITS{1'b1}})) begin
            f_slice = '1;
        end else begin
            f_slice = wide[TIME_BITS-1:0];
        end
    endfunction

    // Advance a ring pointer
    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(LEVEL_DEPTH - 1)) begin
            f_next = '0;
        end else begin
            f_next = PTR_W'(ptr + 1'b1);
        end
    endfunction

    assign o_sts.req_none = (r_req == mfqs_pkg::REQ_NONE);

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= mfqs_pkg::t_req_type'(i_req_type);
            r_pid  <= i_process_id;
            r_preq <= i_priority_req;
            r_last <= i_last_run_time;
            r_cpu  <= i_cpu_remaining;
            r_io   <= i_time_until_io;
        end
    end

    // Adjust level of an added process by its last run against the slice
    always_comb begin
        add_lvl   = r_preq[LVL_W-1:0];
        add_slice = f_slice(r_base, add_lvl);
        n_lvl_add = add_lvl;
        if (r_last >= add_slice) begin
            if (add_lvl != LVL_W'(NUM_LEVELS - 1)) begin
                n_lvl_add = LVL_W'(add_lvl + 1'b1);
            end
        end else if ({r_last, 1'b0} < {1'b0, add_slice}) begin
            if (add_lvl != '0) begin
                n_lvl_add = LVL_W'(add_lvl - 1'b1);
            end
        end
    end

    // Find the lowest-numbered non-empty level
    always_comb begin
        first_lvl = '0;
        any_level = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) begin
                first_lvl = LVL_W'(i);
                any_level = 1'b1;
            end
        end
    end

    assign rd_addr = ADDR_W'(ADDR_W'(first_lvl) * ADDR_W'(LEVEL_DEPTH))
                   + ADDR_W'(r_head[first_lvl]);
    assign wr_addr = ADDR_W'(ADDR_W'(r_lvl) * ADDR_W'(LEVEL_DEPTH))
                   + ADDR_W'(r_tail[r_lvl]);

    // Register the decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_lvl   <= (r_req == mfqs_pkg::REQ_ADD) ? n_lvl_add : first_lvl;
            r_empty <= !any_level;
            r_slice <= f_slice(r_base, first_lvl);
        end
    end

    // Entry memory: write on add, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {r_pid, r_cpu, r_io};
        end
        if (i_cmd.decide) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign rd_id  = r_rd[ENT_W-1 -: mfqs_pkg::ID_W];
    assign rd_cpu = r_rd[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_io  = r_rd[TIME_BITS-1:0];

    assign bad_prio = ({1'b0, r_preq} >= (mfqs_pkg::PRIO_W + 1)'(NUM_LEVELS));
    assign lvl_full = (r_cnt[r_lvl] == CNT_W'(LEVEL_DEPTH));

    // Form the result and queue updates
    always_comb begin
        n_status  = mfqs_pkg::ST_OK;
        n_opid    = '0;
        n_oprio   = '0;
        n_ocpu    = '0;
        n_oio     = '0;
        n_oslice  = '0;
        n_oreason = mfqs_pkg::RSN_NONE;
        wr_en     = 1'b0;
        pop_en    = 1'b0;
        case (r_req)
            mfqs_pkg::REQ_ADD: begin
                n_opid = r_pid;
                if (bad_prio) begin
                    n_status = mfqs_pkg::ST_BAD_PRIO;
                end else begin
                    n_oprio = mfqs_pkg::OPRIO_W'(r_lvl);
                    if (lvl_full) begin
                        n_status = mfqs_pkg::ST_FULL;
                    end else begin
                        wr_en = i_cmd.exec;
                    end
                end
            end
            mfqs_pkg::REQ_GET, mfqs_pkg::REQ_PEEK: begin
                if (r_empty) begin
                    n_status = mfqs_pkg::ST_EMPTY;
                end else begin
                    n_opid  = rd_id;
                    n_oprio = mfqs_pkg::OPRIO_W'(r_lvl);
                    n_ocpu  = rd_cpu;
                    n_oio   = rd_io;
                    if (r_req == mfqs_pkg::REQ_GET) begin
                        pop_en = i_cmd.exec;
                    end else if (rd_cpu == '0) begin
                        n_oreason = mfqs_pkg::RSN_DONE_IO;
                    end else if (rd_io <= rd_cpu && rd_io <= r_slice) begin
                        n_oslice  = rd_io;
                        n_oreason = mfqs_pkg::RSN_DONE_IO;
                    end else if (r_slice == '0) begin
                        n_oreason = mfqs_pkg::RSN_SLICE;
                    end else begin
                        n_oreason = mfqs_pkg::RSN_OTHER;
                    end
                end
            end
            default: begin
                n_status = mfqs_pkg::ST_OK;
            end
        endcase
    end

    // Hold the result for the strobe cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_opid    <= n_opid;
            r_oprio   <= n_oprio;
            r_ocpu    <= n_ocpu;
            r_oio     <= n_oio;
            r_oslice  <= n_oslice;
            r_oreason <= n_oreason;
        end
    end

    // Base slice and level pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= mfqs_pkg::CFG_RESET;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cmd.cfg_we) begin
                r_base <= i_base_slice;
            end
            if (wr_en) begin
                r_tail[r_lvl] <= f_next(r_tail[r_lvl]);
                r_cnt[r_lvl]  <= CNT_W'(r_cnt[r_lvl] + 1'b1);
            end
            if (pop_en) begin
                r_head[r_lvl] <= f_next(r_head[r_lvl]);
                r_cnt[r_lvl]  <= CNT_W'(r_cnt[r_lvl] - 1'b1);
            end
        end
    end

    assign o_status            = r_status;
    assign o_out_process_id    = r_opid;
    assign o_out_priority      = r_oprio;
    assign o_out_cpu_remaining = r_ocpu;
    assign o_out_time_until_io = r_oio;
    assign o_slice_length      = r_oslice;
    assign o_reason            = r_oreason;

    // A pop or peek that finds data reads a level that holds entries
    `MFQS_ASSERT_IMP(a_head_level_nonempty, i_cmd.exec && !r_empty && (r_req == mfqs_pkg::REQ_GET || r_req == mfqs_pkg::REQ_PEEK), r_cnt[r_lvl] != '0)
    `MFQS_ASSERT(a_no_push_and_pop, !(wr_en && pop_en))

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl_chk
        `MFQS_ASSERT(a_cnt_bound, r_cnt[g] <= CNT_W'(LEVEL_DEPTH))
        `MFQS_ASSERT_IMP(a_empty_ptrs, r_cnt[g] == '0, r_head[g] == r_tail[g])
    end

endmodule

// ===== hw/rtl/multilevel_feedback_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Feedback queue scheduler (eight levels by default): add, get and peek.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the request fields and raise start; the beat is
//   taken at a clock edge where start is high and busy is low.
//   Result channel: o_done is high for one cycle with the result fields; the
//   receiver cannot stall it and must take the beat in that cycle.
//   Config channel: i_base_slice is written when i_cfg_valid and o_cfg_ready
//   are both high; o_cfg_ready is high whenever no request is in flight.
// Timing:
//   A request passes through a decide state (level pick, slice compute,
//   registered entry memory read) and an execute state; o_done rises in the
//   cycle after execute, the same cycle in which busy is low again. A new
//   request is taken only once the previous one has returned to idle. The
//   none request code goes from decide back to idle without execute and
//   gives no result.
// Reset:
//   Synchronous active-low reset empties every level and loads a base slice
//   of 10. Entry memory contents are not cleared.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
    parameter int NUM_LEVELS  = mfqs_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mfqs_pkg::LEVEL_DEPTH_DEF,
    parameter int TIME_BITS   = mfqs_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mfqs_pkg::CODE_W-1:0]   i_req_type,
    input  logic [mfqs_pkg::ID_W-1:0]     i_process_id,
    input  logic [mfqs_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [TIME_BITS-1:0]          i_last_run_time,
    input  logic [TIME_BITS-1:0]          i_cpu_remaining,
    input  logic [TIME_BITS-1:0]          i_time_until_io,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mfqs_pkg::CFG_W-1:0]    i_base_slice,
    output logic                          o_done,
    output logic [mfqs_pkg::CODE_W-1:0]   o_status,
    output logic [mfqs_pkg::ID_W-1:0]     o_out_process_id,
    output logic [mfqs_pkg::OPRIO_W-1:0]  o_out_priority,
    output logic [TIME_BITS-1:0]          o_out_cpu_remaining,
    output logic [TIME_BITS-1:0]          o_out_time_until_io,
    output logic [TIME_BITS-1:0]          o_slice_length,
    output logic [mfqs_pkg::CODE_W-1:0]   o_reason
);

    mfqs_pkg::t_dp_cmd dp_cmd;
    mfqs_pkg::t_dp_sts dp_sts;

    // Sequencer
    mfqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_done      (o_done),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Queues and result datapath
    mfqs_dpath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (dp_cmd),
        .o_sts               (dp_sts),
        .i_req_type          (i_req_type),
        .i_process_id        (i_process_id),
        .i_priority_req      (i_priority_req),
        .i_last_run_time     (i_last_run_time),
        .i_cpu_remaining     (i_cpu_remaining),
        .i_time_until_io     (i_time_until_io),
        .i_base_slice        (i_base_slice),
        .o_status            (o_status),
        .o_out_process_id    (o_out_process_id),
        .o_out_priority      (o_out_priority),
        .o_out_cpu_remaining (o_out_cpu_remaining),
        .o_out_time_until_io (o_out_time_until_io),
        .o_slice_length      (o_slice_length),
        .o_reason            (o_reason)
    );

endmodule
